/* hw/rtl/cfl_pkg.sv */
// ----------------------------------------------------------------------------
// Curvature feedrate limit package
// Field widths, configuration layout, register indexes and pipeline depths
// shared by the feedrate limit modules.
// ----------------------------------------------------------------------------
package cfl_pkg;

  // Field and register widths.
  localparam int unsigned CurvW    = 32;
  localparam int unsigned VelW     = 32;
  localparam int unsigned AccW     = 48;
  localparam int unsigned JerkW    = 48;
  localparam int unsigned ChordW   = 32;
  localparam int unsigned PeriodW  = 32;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned CfgIdxW  = 3;

  // Radius is floor(2^48 / curvature), Q17.32, at most 2^48.
  localparam int unsigned RadW = 49;

  localparam logic [VelW-1:0] VelSat = '1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxVelocity     = 3'd0,
    CfgMaxAcceleration = 3'd1,
    CfgMaxJerk         = 3'd2,
    CfgChordError      = 3'd3,
    CfgSamplePeriod    = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [VelW-1:0]    RstMaxVelocity     = 32'd6553600;
  localparam logic [AccW-1:0]    RstMaxAcceleration = 48'd65536000;
  localparam logic [JerkW-1:0]   RstMaxJerk         = 48'd655360000;
  localparam logic [ChordW-1:0]  RstChordError      = 32'd16777;
  localparam logic [PeriodW-1:0] RstSamplePeriod    = 32'd4294967;

  typedef struct packed {
    logic [VelW-1:0]    max_velocity;
    logic [AccW-1:0]    max_acceleration;
    logic [JerkW-1:0]   max_jerk;
    logic [ChordW-1:0]  chord_error;
    logic [PeriodW-1:0] sample_period;
  } cfg_t;

  // Pipeline depths, in register stages. The acceleration and jerk depths
  // leave out their select stage, which is the first stage of their padding.
  localparam int unsigned RecipLat       = RadW;
  localparam int unsigned ChordSqrtSteps = 62;
  localparam int unsigned ChordDivSteps  = 32;
  localparam int unsigned ChordLat       = 3 + ChordSqrtSteps + 1 + ChordDivSteps + 1;
  localparam int unsigned AccelSqrtSteps = 32;
  localparam int unsigned AccelLat       = 2 + AccelSqrtSteps;
  localparam int unsigned JerkCbrtSteps  = 32;
  localparam int unsigned JerkLat        = 5 + JerkCbrtSteps;
  localparam int unsigned TermLat        = ChordLat;
  localparam int unsigned AccelPad       = TermLat - AccelLat;
  localparam int unsigned JerkPad        = TermLat - JerkLat;
  localparam int unsigned TotalLat       = RecipLat + TermLat + 1;

endpackage

/* hw/rtl/curvature_feedrate_limit.sv */
// ----------------------------------------------------------------------------
// Curvature feedrate limit
// Turns a path curvature into the largest velocity allowed by the chord
// error, velocity, acceleration and jerk limits.
//
//   Channel  Signals                                   Direction
//   in       in_valid_i, in_stall_o, curvature_i      into the block
//   out      out_valid_o, out_stall_i, velocity_limit_o  out of the block
//   cfg      cfg_we_i, cfg_index_i, cfg_wdata_i       into the block
//
// One transaction enters per cycle unless a result is stalled at the output;
// the pipeline depth is set by the 49-stage reciprocal, the chord term with
// its 62-stage square root and 32-stage divider, and the final minimum stage.
// Reset clears the valid bits and loads the configuration defaults.
// A stall at the output freezes the whole pipeline; nothing is lost or
// repeated.
// ----------------------------------------------------------------------------
module curvature_feedrate_limit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [cfl_pkg::CurvW-1:0]    curvature_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cfl_pkg::VelW-1:0]     velocity_limit_o,
  input  logic                         cfg_we_i,
  input  logic [cfl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cfl_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned TotalLat = cfl_pkg::TotalLat;

  // Configuration registers.
  cfl_pkg::cfg_t cfg_q;
  cfl_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        cfl_pkg::CfgMaxVelocity:     cfg_d.max_velocity     = cfg_wdata_i[31:0];
        cfl_pkg::CfgMaxAcceleration: cfg_d.max_acceleration = cfg_wdata_i[47:0];
        cfl_pkg::CfgMaxJerk:         cfg_d.max_jerk         = cfg_wdata_i[47:0];
        cfl_pkg::CfgChordError:      cfg_d.chord_error      = cfg_wdata_i[31:0];
        cfl_pkg::CfgSamplePeriod:    cfg_d.sample_period    = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_velocity     <= cfl_pkg::RstMaxVelocity;
      cfg_q.max_acceleration <= cfl_pkg::RstMaxAcceleration;
      cfg_q.max_jerk         <= cfl_pkg::RstMaxJerk;
      cfg_q.chord_error      <= cfl_pkg::RstChordError;
      cfg_q.sample_period    <= cfl_pkg::RstSamplePeriod;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The pipeline advances unless a finished result is held at the output.
  logic                adv;
  logic [TotalLat-1:0] valid_q;
  logic [TotalLat-2:0] zero_q;

  assign adv        = !(valid_q[TotalLat-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[TotalLat-2:0], in_valid_i};
    end
  end

  // Straight-path flag travels beside the data.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q <= {zero_q[TotalLat-3:0], curvature_i == '0};
    end
  end

  // Radius and the three limit terms.
  logic [cfl_pkg::RadW-1:0] radius;
  logic [cfl_pkg::VelW-1:0] chord_vel;
  logic [cfl_pkg::VelW-1:0] accel_vel;
  logic [cfl_pkg::VelW-1:0] jerk_vel;

  cfl_recip u_recip (
    .clk_i       (clk_i),
    .en_i        (adv),
    .curvature_i (curvature_i),
    .radius_o    (radius)
  );

  cfl_chord u_chord (
    .clk_i       (clk_i),
    .en_i        (adv),
    .radius_i    (radius),
    .cfg_i       (cfg_q),
    .chord_vel_o (chord_vel)
  );

  cfl_accel u_accel (
    .clk_i       (clk_i),
    .en_i        (adv),
    .radius_i    (radius),
    .cfg_i       (cfg_q),
    .accel_vel_o (accel_vel)
  );

  cfl_jerk u_jerk (
    .clk_i      (clk_i),
    .en_i       (adv),
    .radius_i   (radius),
    .cfg_i      (cfg_q),
    .jerk_vel_o (jerk_vel)
  );

  // Minimum of the four limits.
  logic [cfl_pkg::VelW-1:0] lim;
  always_comb begin
    lim = chord_vel;
    if (lim > cfg_q.max_velocity) begin
      lim = cfg_q.max_velocity;
    end
    if (lim > accel_vel) begin
      lim = accel_vel;
    end
    if (lim > jerk_vel) begin
      lim = jerk_vel;
    end
  end

  // Output register.
  logic [cfl_pkg::VelW-1:0] vel_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vel_q <= zero_q[TotalLat-2] ? '0 : lim;
    end
  end

  assign out_valid_o      = valid_q[TotalLat-1];
  assign velocity_limit_o = vel_q;

endmodule

/* hw/rtl/cfl_recip.sv */
// ----------------------------------------------------------------------------
// Reciprocal pipeline
// Restoring division of 2^48 by the curvature, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cfl_recip (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [cfl_pkg::CurvW-1:0] curvature_i,
  output logic [cfl_pkg::RadW-1:0]  radius_o
);

  localparam int unsigned N = cfl_pkg::RecipLat;

  logic [cfl_pkg::CurvW-1:0] rem_q [N];
  logic [cfl_pkg::CurvW-1:0] div_q [N];
  logic [cfl_pkg::RadW-1:0]  quo_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [cfl_pkg::CurvW-1:0] rem_in;
    logic [cfl_pkg::CurvW-1:0] div_in;
    logic [cfl_pkg::RadW-1:0]  quo_in;
    logic [cfl_pkg::CurvW:0]   trial;
    logic [cfl_pkg::CurvW:0]   rem_d;
    logic                      take;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = curvature_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Only the top bit of the dividend is set.
    assign trial = {rem_in, (k == 0) ? 1'b1 : 1'b0};
    assign take  = trial >= {1'b0, div_in};
    assign rem_d = take ? (trial - {1'b0, div_in}) : trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d[cfl_pkg::CurvW-1:0];
        div_q[k] <= div_in;
        quo_q[k] <= {quo_in[cfl_pkg::RadW-2:0], take};
      end
    end
  end

  assign radius_o = quo_q[N-1];

endmodule

/* hw/rtl/cfl_chord.sv */
// ----------------------------------------------------------------------------
// Chord-error term
// Computes floor(sqrt(ce*(2R - ce) * 2^42) / ts) with saturation, through
// product stages, a pipelined square root and a pipelined divider.
// ----------------------------------------------------------------------------
module cfl_chord (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [cfl_pkg::RadW-1:0] radius_i,
  input  cfl_pkg::cfg_t            cfg_i,
  output logic [cfl_pkg::VelW-1:0] chord_vel_o
);

  localparam int unsigned SqN = cfl_pkg::ChordSqrtSteps;
  localparam int unsigned DvN = cfl_pkg::ChordDivSteps;

  logic [31:0] ce;
  logic [31:0] ts;
  assign ce = cfg_i.chord_error;
  assign ts = cfg_i.sample_period;

  // Radius test and the 2R - ce operand.
  logic        cond_s1_q;
  logic [49:0] w_s1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cond_s1_q <= radius_i > {10'b0, ce, 7'b0};
      w_s1_q    <= {radius_i, 1'b0} - {10'b0, ce, 8'b0};
    end
  end

  // Two partial products of ce * w.
  logic        cond_s2_q;
  logic [56:0] plo_s2_q;
  logic [56:0] phi_s2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cond_s2_q <= cond_s1_q;
      plo_s2_q  <= ce * w_s1_q[24:0];
      phi_s2_q  <= ce * w_s1_q[49:25];
    end
  end

  // Sum into the 82-bit radicand.
  logic        cond_s3_q;
  logic [81:0] d_s3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cond_s3_q <= cond_s2_q;
      d_s3_q    <= {25'b0, plo_s2_q} + {phi_s2_q, 25'b0};
    end
  end

  // Square root of d * 2^42, one root bit per stage. The low 42 radicand
  // bits are zero, so the shift register simply runs empty.
  logic [81:0] rad_q  [SqN];
  logic [63:0] srem_q [SqN];
  logic [61:0] root_q [SqN];
  logic        scond_q [SqN];

  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    logic [81:0] rad_in;
    logic [63:0] rem_in;
    logic [61:0] root_in;
    logic        cond_in;
    logic [65:0] x;
    logic [65:0] trial;
    logic [65:0] rem_d;
    logic        ge;

    if (k == 0) begin : g_first
      assign rad_in  = d_s3_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign cond_in = cond_s3_q;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = srem_q[k-1];
      assign root_in = root_q[k-1];
      assign cond_in = scond_q[k-1];
    end

    assign x     = {rem_in, rad_in[81:80]};
    assign trial = {2'b0, root_in, 2'b01};
    assign ge    = x >= trial;
    assign rem_d = ge ? (x - trial) : x;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]   <= {rad_in[79:0], 2'b00};
        srem_q[k]  <= rem_d[63:0];
        root_q[k]  <= {root_in[60:0], ge};
        scond_q[k] <= cond_in;
      end
    end
  end

  // Divider setup: a quotient of 2^32 or more saturates.
  logic        cond_q0_q;
  logic        sat_q0_q;
  logic [31:0] rem_q0_q;
  logic [31:0] low_q0_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cond_q0_q <= scond_q[SqN-1];
      sat_q0_q  <= {2'b0, root_q[SqN-1][61:32]} >= ts;
      rem_q0_q  <= {2'b0, root_q[SqN-1][61:32]};
      low_q0_q  <= root_q[SqN-1][31:0];
    end
  end

  // Restoring division by the sample period, one quotient bit per stage.
  logic [31:0] drem_q  [DvN];
  logic [31:0] dlow_q  [DvN];
  logic [31:0] dquo_q  [DvN];
  logic        dcond_q [DvN];
  logic        dsat_q  [DvN];

  for (genvar k = 0; k < DvN; k++) begin : g_div
    logic [31:0] rem_in;
    logic [31:0] low_in;
    logic [31:0] quo_in;
    logic        cond_in;
    logic        sat_in;
    logic [32:0] x;
    logic [32:0] rem_d;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_q0_q;
      assign low_in  = low_q0_q;
      assign quo_in  = '0;
      assign cond_in = cond_q0_q;
      assign sat_in  = sat_q0_q;
    end else begin : g_next
      assign rem_in  = drem_q[k-1];
      assign low_in  = dlow_q[k-1];
      assign quo_in  = dquo_q[k-1];
      assign cond_in = dcond_q[k-1];
      assign sat_in  = dsat_q[k-1];
    end

    assign x     = {rem_in, low_in[31]};
    assign ge    = x >= {1'b0, ts};
    assign rem_d = ge ? (x - {1'b0, ts}) : x;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[k]  <= rem_d[31:0];
        dlow_q[k]  <= {low_in[30:0], 1'b0};
        dquo_q[k]  <= {quo_in[30:0], ge};
        dcond_q[k] <= cond_in;
        dsat_q[k]  <= sat_in;
      end
    end
  end

  // Final select: radius too small gives zero, overflow saturates.
  logic [31:0] vel_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!dcond_q[DvN-1]) begin
        vel_q <= '0;
      end else if (dsat_q[DvN-1]) begin
        vel_q <= cfl_pkg::VelSat;
      end else begin
        vel_q <= dquo_q[DvN-1];
      end
    end
  end

  assign chord_vel_o = vel_q;

endmodule

/* hw/rtl/cfl_accel.sv */
// ----------------------------------------------------------------------------
// Acceleration term
// Computes floor(sqrt(a*R / 2^16)) with saturation through a partial product
// stage, a sum stage and a pipelined square root, then pads to term depth.
// ----------------------------------------------------------------------------
module cfl_accel (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [cfl_pkg::RadW-1:0] radius_i,
  input  cfl_pkg::cfg_t            cfg_i,
  output logic [cfl_pkg::VelW-1:0] accel_vel_o
);

  localparam int unsigned SqN = cfl_pkg::AccelSqrtSteps;
  localparam int unsigned PadN = cfl_pkg::AccelPad;

  logic [47:0] acc;
  assign acc = cfg_i.max_acceleration;

  // Four partial products of a * R.
  logic [48:0] pp_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= acc[23:0] * radius_i[24:0];
      pp_q[1] <= acc[23:0] * radius_i[48:25];
      pp_q[2] <= acc[47:24] * radius_i[24:0];
      pp_q[3] <= acc[47:24] * radius_i[48:25];
    end
  end

  // Full product, then drop the Q16 scale.
  logic [96:0] prod;
  assign prod = 97'(pp_q[0]) + (97'(pp_q[1]) << 25) + (97'(pp_q[2]) << 24)
              + (97'(pp_q[3]) << 49);

  logic        sat_q;
  logic [63:0] y_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= |prod[96:80];
      y_q   <= prod[79:16];
    end
  end

  // Square root, one root bit per stage.
  logic [63:0] rad_q  [SqN];
  logic [32:0] rem_q  [SqN];
  logic [31:0] root_q [SqN];
  logic        ssat_q [SqN];

  for (genvar k = 0; k < SqN; k++) begin : g_sqrt
    logic [63:0] rad_in;
    logic [32:0] rem_in;
    logic [31:0] root_in;
    logic        sat_in;
    logic [34:0] x;
    logic [34:0] trial;
    logic [34:0] rem_d;
    logic        ge;

    if (k == 0) begin : g_first
      assign rad_in  = y_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sat_in  = sat_q;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sat_in  = ssat_q[k-1];
    end

    assign x     = {rem_in, rad_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = x >= trial;
    assign rem_d = ge ? (x - trial) : x;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[61:0], 2'b00};
        rem_q[k]  <= rem_d[32:0];
        root_q[k] <= {root_in[30:0], ge};
        ssat_q[k] <= sat_in;
      end
    end
  end

  // Saturating result, then delay to match the chord term.
  logic [31:0] pad_q [PadN];
  for (genvar k = 0; k < PadN; k++) begin : g_pad
    logic [31:0] pad_in;
    if (k == 0) begin : g_first
      assign pad_in = ssat_q[SqN-1] ? cfl_pkg::VelSat : root_q[SqN-1];
    end else begin : g_next
      assign pad_in = pad_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[k] <= pad_in;
      end
    end
  end

  assign accel_vel_o = pad_q[PadN-1];

endmodule

/* hw/rtl/cfl_jerk.sv */
// ----------------------------------------------------------------------------
// Jerk term
// Computes floor(cbrt(j*R^2 / 2^32)) with saturation through product stages
// and a pipelined cube root, then pads to term depth.
// ----------------------------------------------------------------------------
module cfl_jerk (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [cfl_pkg::RadW-1:0] radius_i,
  input  cfl_pkg::cfg_t            cfg_i,
  output logic [cfl_pkg::VelW-1:0] jerk_vel_o
);

  localparam int unsigned CbN  = cfl_pkg::JerkCbrtSteps;
  localparam int unsigned PadN = cfl_pkg::JerkPad;

  logic [47:0] jrk;
  assign jrk = cfg_i.max_jerk;

  // Partial products of R * R.
  logic [49:0] ll_q;
  logic [48:0] lh_q;
  logic [47:0] hh_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= radius_i[24:0] * radius_i[24:0];
      lh_q <= radius_i[24:0] * radius_i[48:25];
      hh_q <= radius_i[48:25] * radius_i[48:25];
    end
  end

  // R squared; the cross term appears twice.
  logic [97:0] r2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r2_q <= {48'b0, ll_q} + {23'b0, lh_q, 26'b0} + {hh_q, 50'b0};
    end
  end

  // Eight partial products of j * R^2.
  logic [48:0] pl_q [4];
  logic [48:0] ph_q [4];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q[0] <= jrk[23:0] * r2_q[24:0];
      pl_q[1] <= jrk[23:0] * r2_q[49:25];
      pl_q[2] <= jrk[23:0] * r2_q[74:50];
      pl_q[3] <= jrk[23:0] * r2_q[97:75];
      ph_q[0] <= jrk[47:24] * r2_q[24:0];
      ph_q[1] <= jrk[47:24] * r2_q[49:25];
      ph_q[2] <= jrk[47:24] * r2_q[74:50];
      ph_q[3] <= jrk[47:24] * r2_q[97:75];
    end
  end

  // Sums for each half of j.
  logic [145:0] hl_q;
  logic [145:0] hh2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hl_q  <= 146'(pl_q[0]) + (146'(pl_q[1]) << 25) + (146'(pl_q[2]) << 50)
             + (146'(pl_q[3]) << 75);
      hh2_q <= 146'(ph_q[0]) + (146'(ph_q[1]) << 25) + (146'(ph_q[2]) << 50)
             + (146'(ph_q[3]) << 75);
    end
  end

  // Full product, then drop the Q32 scale.
  logic [145:0] z;
  assign z = hl_q + (hh2_q << 24);

  logic        sat_q;
  logic [95:0] y_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= |z[145:128];
      y_q   <= z[127:32];
    end
  end

  // Cube root, one root bit per stage; the root square is kept alongside so
  // that no stage needs a multiplier.
  logic [95:0] rad_q  [CbN];
  logic [65:0] rem_q  [CbN];
  logic [31:0] root_q [CbN];
  logic [63:0] sq_q   [CbN];
  logic        csat_q [CbN];

  for (genvar k = 0; k < CbN; k++) begin : g_cbrt
    logic [95:0] rad_in;
    logic [65:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] sq_in;
    logic        sat_in;
    logic [31:0] root2;
    logic [63:0] sq2;
    logic [64:0] s;
    logic [65:0] b;
    logic [68:0] x;
    logic [68:0] rem_d;
    logic        ge;

    if (k == 0) begin : g_first
      assign rad_in  = y_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sq_in   = '0;
      assign sat_in  = sat_q;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sq_in   = sq_q[k-1];
      assign sat_in  = csat_q[k-1];
    end

    // Step (2r+1)^3 - (2r)^3 = 3*(4r^2 + 2r) + 1.
    assign root2 = {root_in[30:0], 1'b0};
    assign sq2   = {sq_in[61:0], 2'b00};
    assign s     = {1'b0, sq2} + {33'b0, root2};
    assign b     = {s, 1'b0} + {1'b0, s} + 66'd1;
    assign x     = {rem_in, rad_in[95:93]};
    assign ge    = x >= {3'b0, b};
    assign rem_d = ge ? (x - {3'b0, b}) : x;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= {rad_in[92:0], 3'b000};
        rem_q[k]  <= rem_d[65:0];
        root_q[k] <= {root_in[30:0], ge};
        sq_q[k]   <= ge ? (sq2 + {31'b0, root2, 1'b0} + 64'd1) : sq2;
        csat_q[k] <= sat_in;
      end
    end
  end

  // Saturating result, then delay to match the chord term.
  logic [31:0] pad_q [PadN];
  for (genvar k = 0; k < PadN; k++) begin : g_pad
    logic [31:0] pad_in;
    if (k == 0) begin : g_first
      assign pad_in = csat_q[CbN-1] ? cfl_pkg::VelSat : root_q[CbN-1];
    end else begin : g_next
      assign pad_in = pad_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pad_q[k] <= pad_in;
      end
    end
  end

  assign jerk_vel_o = pad_q[PadN-1];

endmodule

/* hw/rtl/cfl_checker.sv */
// ----------------------------------------------------------------------------
// Curvature feedrate limit checker
// Port-level assertions on the handshakes, bound to the top level.
// ----------------------------------------------------------------------------
module cfl_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_stall_i,
  input logic                     out_valid_i,
  input logic                     out_stall_i,
  input logic [cfl_pkg::VelW-1:0] velocity_limit_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(velocity_limit_i))
    else $error("result changed while stalled");

  // The input is held off exactly when the output holds a stalled result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i == (out_valid_i && out_stall_i))
    else $error("input stall does not follow output backpressure");

  // No result is offered during reset.
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

endmodule

bind curvature_feedrate_limit cfl_checker u_cfl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .velocity_limit_i (velocity_limit_o)
);

/* dv/tb_curvature_feedrate_limit.sv */
// ----------------------------------------------------------------------------
// Curvature feedrate limit testbench
// Drives curvature transactions under random idling and back pressure,
// predicts each velocity limit with an exact wide-integer calculation, and
// checks every output transaction in order. Configuration changes happen
// only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_curvature_feedrate_limit;

  localparam int unsigned CycleLimit   = 1500000;
  localparam int unsigned SettleCycles = cfl_pkg::TotalLat + 50;
  localparam int unsigned HoldCycles   = 4 * cfl_pkg::TotalLat;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_stall_o;
  logic [cfl_pkg::CurvW-1:0]    curvature_i;
  logic                         out_valid_o;
  logic                         out_stall_i;
  logic [cfl_pkg::VelW-1:0]     velocity_limit_o;
  logic                         cfg_we_i;
  logic [cfl_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [cfl_pkg::CfgDataW-1:0] cfg_wdata_i;

  // Local copy of the configuration registers.
  logic [cfl_pkg::VelW-1:0]    lim_max_vel;
  logic [cfl_pkg::AccW-1:0]    lim_max_acc;
  logic [cfl_pkg::JerkW-1:0]   lim_max_jerk;
  logic [cfl_pkg::ChordW-1:0]  lim_chord_err;
  logic [cfl_pkg::PeriodW-1:0] lim_period;

  logic [cfl_pkg::VelW-1:0] expected_limits[$];
  int unsigned              mismatches;
  int unsigned              cycle_count;
  bit                       send_idle_en;
  bit                       recv_idle_en;
  logic                     recv_hold_req;
  int unsigned              recv_hold_left;

  curvature_feedrate_limit u_top (.*);

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stall: a counted hold-off takes priority over random idling.
  always @(posedge clk_i) begin
    if (recv_hold_req === 1'b1 && recv_hold_left == 0) begin
      recv_hold_left = HoldCycles;
    end
    if (recv_hold_left > 0) begin
      out_stall_i <= 1'b1;
      recv_hold_left--;
    end else begin
      out_stall_i <= recv_idle_en && ($urandom_range(0, 99) < 19);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("mismatch: %s expected %0h got %0h", what, exp_v, got_v);
    mismatches++;
  endtask

  // Compare each output transaction with the oldest expected limit.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_limits.size() == 0) begin
        report_mismatch("unexpected velocity_limit", 64'd0, 64'(velocity_limit_o));
      end else begin
        if (velocity_limit_o !== expected_limits[0]) begin
          report_mismatch("velocity_limit", 64'(expected_limits[0]),
                          64'(velocity_limit_o));
        end
        void'(expected_limits.pop_front());
      end
    end
  end

  // Largest r below 2^nbits with r^deg * 2^shift <= goal.
  function automatic logic [63:0] int_root(input logic [191:0] goal, input int deg,
                                           input int shift, input int nbits);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [191:0] p;
    r = '0;
    for (int b = nbits - 1; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      p = 192'(cand) * 192'(cand);
      if (deg == 3) p = p * 192'(cand);
      p = p << shift;
      if (p <= goal) r = cand;
    end
    return r;
  endfunction

  // Velocity limit for one curvature under the current configuration.
  function automatic logic [cfl_pkg::VelW-1:0] feed_limit(
      input logic [cfl_pkg::CurvW-1:0] curv);
    logic [63:0]  radius;
    logic [63:0]  span;
    logic [63:0]  root;
    logic [63:0]  v_chord;
    logic [63:0]  v_acc;
    logic [63:0]  v_jerk;
    logic [63:0]  lim;
    logic [191:0] prod;
    if (curv == '0) return '0;
    radius = (64'd1 << 48) / 64'(curv);
    v_chord = '0;
    if (radius > (64'(lim_chord_err) << 7)) begin
      span = (radius << 1) - (64'(lim_chord_err) << 8);
      prod = (192'(lim_chord_err) * 192'(span)) << 42;
      root = int_root(prod, 2, 0, 64);
      if (lim_period == '0) v_chord = 64'(cfl_pkg::VelSat);
      else begin
        v_chord = root / 64'(lim_period);
        if (v_chord > 64'(cfl_pkg::VelSat)) v_chord = 64'(cfl_pkg::VelSat);
      end
    end
    lim = v_chord;
    if (lim > 64'(lim_max_vel)) lim = 64'(lim_max_vel);
    prod = 192'(lim_max_acc) * 192'(radius);
    v_acc = int_root(prod, 2, 16, 32);
    if (lim > v_acc) lim = v_acc;
    prod = 192'(lim_max_jerk) * 192'(radius) * 192'(radius);
    v_jerk = int_root(prod, 3, 32, 32);
    if (lim > v_jerk) lim = v_jerk;
    return lim[cfl_pkg::VelW-1:0];
  endfunction

  // Send one curvature transaction; valid stays high for a possible follower.
  task automatic send_curvature(input logic [cfl_pkg::CurvW-1:0] curv);
    while (send_idle_en && ($urandom_range(0, 99) < 19)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    curvature_i <= curv;
    do @(posedge clk_i); while (in_stall_o);
    expected_limits.push_back(feed_limit(curv));
  endtask

  // Stop offering and wait until every expected limit has arrived.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_limits.size() != 0);
  endtask

  // Register write while the pipeline is empty; the task returns with the write enable low.
  task automatic write_reg(input logic [cfl_pkg::CfgIdxW-1:0] idx,
                           input logic [cfl_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      cfl_pkg::CfgMaxVelocity:     lim_max_vel   = val[cfl_pkg::VelW-1:0];
      cfl_pkg::CfgMaxAcceleration: lim_max_acc   = val[cfl_pkg::AccW-1:0];
      cfl_pkg::CfgMaxJerk:         lim_max_jerk  = val[cfl_pkg::JerkW-1:0];
      cfl_pkg::CfgChordError:      lim_chord_err = val[cfl_pkg::ChordW-1:0];
      cfl_pkg::CfgSamplePeriod:    lim_period    = val[cfl_pkg::PeriodW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Register value: extremes, reset-scale values, or random magnitude.
  function automatic logic [cfl_pkg::CfgDataW-1:0] pick_reg_value(
      input logic [cfl_pkg::CfgDataW-1:0] rst_v);
    logic [cfl_pkg::CfgDataW-1:0] v;
    v = cfl_pkg::CfgDataW'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2, 3: v = rst_v * cfl_pkg::CfgDataW'($urandom_range(1, 64))
                / cfl_pkg::CfgDataW'($urandom_range(1, 64));
      default: v = v >> $urandom_range(0, 47);
    endcase
    return v;
  endfunction

  // Curvature mix: full range, small, near the chord threshold, straight.
  function automatic logic [cfl_pkg::CurvW-1:0] pick_curvature();
    logic [63:0] edge_c;
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return $urandom;
      3, 4: return $urandom >> $urandom_range(0, 31);
      5: begin
        edge_c = (lim_chord_err == '0) ? 64'd1 :
                 (64'd1 << 48) / (64'(lim_chord_err) << 7);
        edge_c = edge_c + 64'($urandom_range(0, 4)) - 64'd2;
        return (edge_c > 64'hFFFF_FFFF) ? '1 : edge_c[cfl_pkg::CurvW-1:0];
      end
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  task automatic test_directed_defaults();
    logic [cfl_pkg::CurvW-1:0] edge_c;
    edge_c = 32'((64'd1 << 48) / (64'(lim_chord_err) << 7));
    send_curvature('0);
    send_curvature(32'd1);
    send_curvature('1);
    send_curvature(32'h0001_0000);
    send_curvature(32'h8000_0000);
    send_curvature(32'h5555_5555);
    send_curvature(32'hAAAA_AAAA);
    send_curvature(edge_c - 32'd1);
    send_curvature(edge_c);
    send_curvature(edge_c + 32'd1);
    drain_pipeline();
  endtask

  task automatic test_directed_special();
    // Zero chord error and zero sample period.
    write_reg(cfl_pkg::CfgChordError, '0);
    send_curvature(32'h0000_0100);
    send_curvature(32'h0001_0000);
    drain_pipeline();
    write_reg(cfl_pkg::CfgChordError, 48'd16777);
    write_reg(cfl_pkg::CfgSamplePeriod, '0);
    send_curvature(32'h0000_0100);
    send_curvature(32'd1);
    drain_pipeline();
    // Limits at their ceiling and a sample period of one, so that every term saturates for the largest radii.
    write_reg(cfl_pkg::CfgMaxVelocity, '1);
    write_reg(cfl_pkg::CfgMaxAcceleration, '1);
    write_reg(cfl_pkg::CfgMaxJerk, '1);
    write_reg(cfl_pkg::CfgChordError, '1);
    write_reg(cfl_pkg::CfgSamplePeriod, 48'd1);
    send_curvature(32'd1);
    send_curvature(32'd2);
    send_curvature('1);
    drain_pipeline();
    // Writes past the register list are dropped; wide data is masked.
    for (int k = 1; k <= 3; k++) begin
      write_reg(cfl_pkg::CfgIdxW'(cfl_pkg::CfgSamplePeriod + k), '0);
    end
    write_reg(cfl_pkg::CfgMaxVelocity, 48'hABCD_0064_0000);
    write_reg(cfl_pkg::CfgChordError, 48'h1234_0000_4189);
    send_curvature(32'h0000_0200);
    send_curvature(32'd3);
    drain_pipeline();
  endtask

  task automatic test_random_phases(input int n_phases, input int n_items);
    for (int ph = 0; ph < n_phases; ph++) begin
      write_reg(cfl_pkg::CfgMaxVelocity,
                pick_reg_value(cfl_pkg::CfgDataW'(cfl_pkg::RstMaxVelocity)));
      write_reg(cfl_pkg::CfgMaxAcceleration, pick_reg_value(cfl_pkg::RstMaxAcceleration));
      write_reg(cfl_pkg::CfgMaxJerk, pick_reg_value(cfl_pkg::RstMaxJerk));
      write_reg(cfl_pkg::CfgChordError,
                pick_reg_value(cfl_pkg::CfgDataW'(cfl_pkg::RstChordError)));
      write_reg(cfl_pkg::CfgSamplePeriod,
                pick_reg_value(cfl_pkg::CfgDataW'(cfl_pkg::RstSamplePeriod)));
      for (int i = 0; i < n_items; i++) send_curvature(pick_curvature());
      drain_pipeline();
    end
  endtask

  task automatic test_no_idle_stretch();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (int i = 0; i < 200; i++) send_curvature(pick_curvature());
    drain_pipeline();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    // The receiver holds off long enough for the pipeline to fill and stall.
    recv_hold_req <= 1'b1;
    @(posedge clk_i);
    recv_hold_req <= 1'b0;
    send_idle_en = 1'b0;
    for (int i = 0; i < 2 * cfl_pkg::TotalLat; i++) send_curvature(pick_curvature());
    send_idle_en = 1'b1;
    drain_pipeline();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    curvature_i    = '0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_wdata_i    = '0;
    recv_hold_req  = 1'b0;
    send_idle_en   = 1'b1;
    recv_idle_en   = 1'b1;
    lim_max_vel    = cfl_pkg::RstMaxVelocity;
    lim_max_acc    = cfl_pkg::RstMaxAcceleration;
    lim_max_jerk   = cfl_pkg::RstMaxJerk;
    lim_chord_err  = cfl_pkg::RstChordError;
    lim_period     = cfl_pkg::RstSamplePeriod;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    test_directed_special();
    test_random_phases(6, 115);
    test_no_idle_stretch();
    test_backpressure();

    drain_pipeline();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cfl_pkg.sv
hw/rtl/cfl_recip.sv
hw/rtl/cfl_chord.sv
hw/rtl/cfl_accel.sv
hw/rtl/cfl_jerk.sv
hw/rtl/curvature_feedrate_limit.sv
hw/rtl/cfl_checker.sv
dv/tb_curvature_feedrate_limit.sv
